>>> hdl/mspd_pkg.sv
// ----------------------------------------------------------------------------
// MSP deframer package
// Shared widths, result word layout, result kinds and the CRC-8 update.
// ----------------------------------------------------------------------------
package mspd_pkg;

  localparam int LEN_WIDTH_DEF = 16;
  localparam int CODE_W        = 16;
  localparam int SIZE_W        = 16;

  localparam logic [7:0] CHAR_START = 8'h24;  // '$'
  localparam logic [7:0] CHAR_V1    = 8'h4D;  // 'M'
  localparam logic [7:0] CHAR_V2    = 8'h58;  // 'X'
  localparam logic [7:0] CHAR_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CRC_POLY   = 8'hD5;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        data_byte;
    logic              frame_version;
    logic [CODE_W-1:0] command_code;
    logic [SIZE_W-1:0] payload_size;
    logic [7:0]        received_check;
    logic [7:0]        computed_check;
  } mspd_result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/mspd_in_stage.sv
// ----------------------------------------------------------------------------
// MSP deframer input stage
// Registers one received word and releases it when the decoder consumes it.
// ----------------------------------------------------------------------------
module mspd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || take_i;
  assign valid_o  = valid_r;
  assign byte_o   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

>>> hdl/mspd_decoder.sv
// ----------------------------------------------------------------------------
// MSP deframer decoder
// Frame state machine, header capture and running XOR / CRC-8 check.
// ----------------------------------------------------------------------------
module mspd_decoder #(
  parameter int LENGTH_WIDTH = mspd_pkg::LEN_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output logic                 has_res_o,
  output mspd_pkg::mspd_result_t res_o
);
  import mspd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd1,
    PH_VERSION = 3'd2,
    PH_HEADER  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic                    version_r, version_nxt;
  logic [2:0]              hidx_r, hidx_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic [CODE_W-1:0]       cmd_r, cmd_nxt;
  logic [LENGTH_WIDTH-1:0] seen_r, seen_nxt;
  logic [7:0]              check_r, check_nxt;

  logic [7:0]              check_upd;
  logic [LENGTH_WIDTH-1:0] seen_inc;
  logic [LENGTH_WIDTH-1:0] len_v2;

  assign check_upd = version_r ? crc8_update(check_r, byte_i) : (check_r ^ byte_i);
  assign seen_inc  = seen_r + 1'b1;
  assign len_v2    = LENGTH_WIDTH'({byte_i, len_r[7:0]});

  always_comb begin
    phase_nxt   = phase_r;
    version_nxt = version_r;
    hidx_nxt    = hidx_r;
    len_nxt     = len_r;
    cmd_nxt     = cmd_r;
    seen_nxt    = seen_r;
    check_nxt   = check_r;
    has_res_o   = 1'b0;
    res_o.kind           = KIND_DATA;
    res_o.data_byte      = 8'd0;
    res_o.frame_version  = version_r;
    res_o.command_code   = cmd_r;
    res_o.payload_size   = SIZE_W'(len_r);
    res_o.received_check = 8'd0;
    res_o.computed_check = 8'd0;
    unique case (phase_r)
      PH_START: begin
        if (byte_i == CHAR_V1) begin
          version_nxt = 1'b0;
          phase_nxt   = PH_VERSION;
        end else if (byte_i == CHAR_V2) begin
          version_nxt = 1'b1;
          phase_nxt   = PH_VERSION;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_VERSION: begin
        if (byte_i == CHAR_LT || byte_i == CHAR_GT) begin
          phase_nxt = PH_HEADER;
          hidx_nxt  = 3'd0;
          len_nxt   = '0;
          cmd_nxt   = '0;
          seen_nxt  = '0;
          check_nxt = 8'd0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_HEADER: begin
        check_nxt = check_upd;
        if (!version_r) begin
          if (hidx_r == 3'd0) begin
            len_nxt  = LENGTH_WIDTH'(byte_i);
            hidx_nxt = 3'd1;
          end else begin
            cmd_nxt   = CODE_W'(byte_i);
            seen_nxt  = '0;
            phase_nxt = (len_r == '0) ? PH_CHECK : PH_PAYLOAD;
          end
        end else begin
          unique case (hidx_r)
            3'd0: hidx_nxt = 3'd1;
            3'd1: begin
              cmd_nxt  = CODE_W'(byte_i);
              hidx_nxt = 3'd2;
            end
            3'd2: begin
              cmd_nxt  = {byte_i, cmd_r[7:0]};
              hidx_nxt = 3'd3;
            end
            3'd3: begin
              len_nxt  = LENGTH_WIDTH'(byte_i);
              hidx_nxt = 3'd4;
            end
            default: begin
              len_nxt   = len_v2;
              seen_nxt  = '0;
              phase_nxt = (len_v2 == '0) ? PH_CHECK : PH_PAYLOAD;
            end
          endcase
        end
      end
      PH_PAYLOAD: begin
        check_nxt       = check_upd;
        seen_nxt        = seen_inc;
        if (seen_inc == len_r) phase_nxt = PH_CHECK;
        has_res_o       = 1'b1;
        res_o.data_byte = byte_i;
      end
      PH_CHECK: begin
        has_res_o            = 1'b1;
        res_o.kind           = (byte_i == check_r) ? KIND_GOOD : KIND_BAD;
        res_o.received_check = byte_i;
        res_o.computed_check = check_r;
        phase_nxt            = PH_IDLE;
      end
      default: begin
        phase_nxt = (byte_i == CHAR_START) ? PH_START : PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      version_r <= 1'b0;
      hidx_r    <= 3'd0;
      len_r     <= '0;
      cmd_r     <= '0;
      seen_r    <= '0;
      check_r   <= 8'd0;
    end else if (step_i) begin
      phase_r   <= phase_nxt;
      version_r <= version_nxt;
      hidx_r    <= hidx_nxt;
      len_r     <= len_nxt;
      cmd_r     <= cmd_nxt;
      seen_r    <= seen_nxt;
      check_r   <= check_nxt;
    end
  end

endmodule

>>> hdl/mspd_out_stage.sv
// ----------------------------------------------------------------------------
// MSP deframer output stage
// Result register; holds a word until the consumer takes it.
// ----------------------------------------------------------------------------
module mspd_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load_i,
  input  mspd_pkg::mspd_result_t res_i,
  output logic                   free_o,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mspd_pkg::mspd_result_t res_o
);
  import mspd_pkg::*;

  logic         valid_r;
  mspd_result_t res_r;

  assign free_o    = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_o     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

endmodule

>>> hdl/msp_frame_deframer.sv
// ----------------------------------------------------------------------------
// MSP frame deframer
// Recognizes MSPv1 and MSPv2 frames in a received byte stream.
// ----------------------------------------------------------------------------
// Accepts received bytes and streams each payload byte out as a data word,
// followed by one end word per frame that carries the command or function,
// declared size, received and computed check and the good/bad verdict (XOR
// for v1, CRC-8 poly 0xD5 for v2). It takes one byte per clock, sustained,
// while no untaken word blocks the result register. A byte goes from the
// input register through the decoder into the result register; one that
// yields a word waits in the input register while the result register is blocked.
// Header bytes produce no word. A bad header byte drops back to idle and is
// not taken as a new start. There is no clearing pass after reset.
module msp_frame_deframer #(
  parameter int LENGTH_WIDTH = mspd_pkg::LEN_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [7:0]                  out_data_byte,
  output logic                        out_frame_version,
  output logic [mspd_pkg::CODE_W-1:0] out_command_code,
  output logic [mspd_pkg::SIZE_W-1:0] out_payload_size,
  output logic [7:0]                  out_received_check,
  output logic [7:0]                  out_computed_check
);
  import mspd_pkg::*;

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         take;
  logic         has_res;
  logic         out_free;
  mspd_result_t dec_res;
  mspd_result_t out_res;

  assign take = s1_valid && (!has_res || out_free);

  mspd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take_i     (take),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  mspd_decoder #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (take),
    .byte_i    (s1_byte),
    .has_res_o (has_res),
    .res_o     (dec_res)
  );

  mspd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (take && has_res),
    .res_i     (dec_res),
    .free_o    (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_o     (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_data_byte      = out_res.data_byte;
  assign out_frame_version  = out_res.frame_version;
  assign out_command_code   = out_res.command_code;
  assign out_payload_size   = out_res.payload_size;
  assign out_received_check = out_res.received_check;
  assign out_computed_check = out_res.computed_check;

  a_data_no_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> out_received_check == 8'd0 &&
    out_computed_check == 8'd0)
    else $error("data word carries check bytes");

  a_end_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DATA |-> out_data_byte == 8'd0)
    else $error("end word carries a data byte");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid && has_res && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule

>>> tb/msp_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MSP frame deframer testbench
// Streams MSPv1/MSPv2 frames, broken headers and line noise into the deframer
// under random idling on both sides. A byte-level decoder mirrors the block
// and predicts every payload and frame-end word, which are compared field by
// field against the result channel.
// ----------------------------------------------------------------------------
module msp_frame_deframer_tb;
  import mspd_pkg::*;

  typedef enum logic [2:0] {
    HUNT_IDLE,
    HUNT_START,
    HUNT_VERSION,
    HUNT_HEADER,
    HUNT_PAYLOAD,
    HUNT_CHECK
  } hunt_phase_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_kind;
  logic [7:0]        out_data_byte;
  logic              out_frame_version;
  logic [CODE_W-1:0] out_command_code;
  logic [SIZE_W-1:0] out_payload_size;
  logic [7:0]        out_received_check;
  logic [7:0]        out_computed_check;

  always #1 clk = ~clk;

  msp_frame_deframer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_frame_version  (out_frame_version),
    .out_command_code   (out_command_code),
    .out_payload_size   (out_payload_size),
    .out_received_check (out_received_check),
    .out_computed_check (out_computed_check)
  );

  logic [7:0]   rx_stream[$];
  mspd_result_t expected_words[$];
  int unsigned  n_queued = 0;
  int unsigned  n_taken = 0;
  int           mismatch_count = 0;
  int           tx_idle_pct = 24;
  int           rx_idle_pct = 64;
  bit           hold_req = 1'b0;
  int           hold_cnt = 0;
  logic         word_sent = 1'b0;

  hunt_phase_t  dec_phase = HUNT_IDLE;
  logic         dec_v2 = 1'b0;
  logic [2:0]   dec_hidx = '0;
  logic [15:0]  dec_len = '0;
  logic [15:0]  dec_cmd = '0;
  logic [15:0]  dec_seen = '0;
  logic [7:0]   dec_chk = '0;

  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
    return c;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    mspd_result_t w;
    logic [7:0]   next_chk;
    bit           header_done;
    w = '0;
    w.frame_version = dec_v2;
    w.command_code = dec_cmd;
    w.payload_size = dec_len;
    next_chk = dec_v2 ? crc8_d5(dec_chk, b) : (dec_chk ^ b);
    header_done = 1'b0;
    case (dec_phase)
      HUNT_START: begin
        if (b == CHAR_V1) begin
          dec_v2 = 1'b0;
          dec_phase = HUNT_VERSION;
        end else if (b == CHAR_V2) begin
          dec_v2 = 1'b1;
          dec_phase = HUNT_VERSION;
        end else begin
          dec_phase = HUNT_IDLE;
        end
      end
      HUNT_VERSION: begin
        if (b == CHAR_LT || b == CHAR_GT) begin
          dec_phase = HUNT_HEADER;
          dec_hidx = '0;
          dec_len = '0;
          dec_cmd = '0;
          dec_seen = '0;
          dec_chk = '0;
        end else begin
          dec_phase = HUNT_IDLE;
        end
      end
      HUNT_HEADER: begin
        dec_chk = next_chk;
        if (!dec_v2) begin
          if (dec_hidx == 3'd0) begin
            dec_len = {8'h00, b};
            dec_hidx = 3'd1;
          end else begin
            dec_cmd = {8'h00, b};
            header_done = 1'b1;
          end
        end else begin
          case (dec_hidx)
            3'd0: dec_hidx = 3'd1;
            3'd1: begin
              dec_cmd = {8'h00, b};
              dec_hidx = 3'd2;
            end
            3'd2: begin
              dec_cmd[15:8] = b;
              dec_hidx = 3'd3;
            end
            3'd3: begin
              dec_len = {8'h00, b};
              dec_hidx = 3'd4;
            end
            default: begin
              dec_len[15:8] = b;
              header_done = 1'b1;
            end
          endcase
        end
        if (header_done) begin
          dec_seen = '0;
          dec_phase = (dec_len == 16'd0) ? HUNT_CHECK : HUNT_PAYLOAD;
        end
      end
      HUNT_PAYLOAD: begin
        dec_chk = next_chk;
        dec_seen = dec_seen + 16'd1;
        if (dec_seen == dec_len) dec_phase = HUNT_CHECK;
        w.kind = KIND_DATA;
        w.data_byte = b;
        expected_words.insert(expected_words.size(), w);
      end
      HUNT_CHECK: begin
        w.kind = (b == dec_chk) ? KIND_GOOD : KIND_BAD;
        w.received_check = b;
        w.computed_check = dec_chk;
        expected_words.insert(expected_words.size(), w);
        dec_phase = HUNT_IDLE;
      end
      default: dec_phase = (b == CHAR_START) ? HUNT_START : HUNT_IDLE;
    endcase
  endtask

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    mspd_result_t w;
    word_sent <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      decode_byte(in_rx_byte);
      n_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("out_kind: expected no word, got 0x%0h", out_kind);
        mismatch_count++;
      end else begin
        w = expected_words.pop_front();
        check_field("out_kind", w.kind, out_kind);
        check_field("out_data_byte", w.data_byte, out_data_byte);
        check_field("out_frame_version", w.frame_version, out_frame_version);
        check_field("out_command_code", w.command_code, out_command_code);
        check_field("out_payload_size", w.payload_size, out_payload_size);
        check_field("out_received_check", w.received_check, out_received_check);
        check_field("out_computed_check", w.computed_check, out_computed_check);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_sent) begin
      if (rx_stream.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_stream.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req && hold_cnt < 300) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic put_raw(input logic [7:0] b);
    rx_stream.insert(rx_stream.size(), b);
    n_queued++;
  endtask

  task automatic put_checked(input bit v2, inout logic [7:0] chk, input logic [7:0] b);
    chk = v2 ? crc8_d5(chk, b) : (chk ^ b);
    put_raw(b);
  endtask

  task automatic add_frame(input bit v2, input logic [15:0] cmd, input int unsigned size,
                           input int fill, input bit spoil);
    logic [7:0]  chk;
    logic [15:0] len;
    chk = '0;
    len = size[15:0];
    put_raw(CHAR_START);
    put_raw(v2 ? CHAR_V2 : CHAR_V1);
    put_raw($urandom_range(1) ? CHAR_LT : CHAR_GT);
    if (!v2) begin
      put_checked(v2, chk, len[7:0]);
      put_checked(v2, chk, cmd[7:0]);
    end else begin
      put_checked(v2, chk, 8'($urandom));
      put_checked(v2, chk, cmd[7:0]);
      put_checked(v2, chk, cmd[15:8]);
      put_checked(v2, chk, len[7:0]);
      put_checked(v2, chk, len[15:8]);
    end
    repeat (size) put_checked(v2, chk, (fill < 0) ? 8'($urandom) : fill[7:0]);
    if (spoil) chk = chk ^ 8'($urandom_range(255, 1));
    put_raw(chk);
  endtask

  task automatic queue_random(input int unsigned n_bytes);
    int unsigned first;
    int          r;
    logic [7:0]  b;
    int unsigned sz;
    first = n_queued;
    while (n_queued - first < n_bytes) begin
      r = $urandom_range(99);
      sz = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
      if (r < 78) begin
        add_frame(1'($urandom_range(1)), 16'($urandom), sz, -1, r >= 70);
      end else if (r < 88) begin
        put_raw(CHAR_START);
        case ($urandom_range(2))
          0: begin
            do b = 8'($urandom); while (b == CHAR_V1 || b == CHAR_V2);
            put_raw(b);
          end
          1: begin
            put_raw($urandom_range(1) ? CHAR_V1 : CHAR_V2);
            do b = 8'($urandom); while (b == CHAR_LT || b == CHAR_GT);
            put_raw(b);
          end
          default: put_raw(CHAR_START);
        endcase
      end else begin
        repeat ($urandom_range(6, 1)) put_raw(8'($urandom));
      end
    end
  endtask

  task automatic drain;
    while (n_taken != n_queued || expected_words.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    put_raw(CHAR_START);
    put_raw(CHAR_START);
    put_raw(CHAR_V1);
    put_raw(CHAR_START);
    put_raw(8'h51);
    add_frame(1'b0, 16'h00FF, 0, -1, 1'b0);
    add_frame(1'b1, 16'hFFFF, 1, 8'h00, 1'b0);
    add_frame(1'b0, 16'h0000, 1, 8'hFF, 1'b1);
    queue_random(330);
    drain();

    tx_idle_pct = 64;
    rx_idle_pct = 24;
    queue_random(330);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    add_frame(1'b1, 16'($urandom), 257, -1, 1'b0);
    queue_random(330);
    drain();

    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> msp_frame_deframer.f
hdl/mspd_pkg.sv
hdl/mspd_in_stage.sv
hdl/mspd_decoder.sv
hdl/mspd_out_stage.sv
hdl/msp_frame_deframer.sv
tb/msp_frame_deframer_tb.sv
